/* hw/rtl/lmsr_pkg.sv */
// shared types, constants and command/status structs for the recognizer
package lmsr_pkg;

    localparam int STATE_COUNT  = 1024;
    localparam int CELL_COUNT   = 4096;
    localparam int OPCODE_COUNT = 128;
    localparam int MAX_SEQ_LEN  = 8;
    localparam int MAX_RESULTS  = 8;
    localparam int STACK_DEPTH  = 1 + MAX_RESULTS * MAX_SEQ_LEN;
    localparam int SP_W         = $clog2(STACK_DEPTH + 1);
    localparam int RES_W        = $clog2(MAX_RESULTS + 1);

    // request function codes
    typedef enum logic [1:0] {
        FUNC_FEED  = 2'd0,
        FUNC_END   = 2'd1,
        FUNC_STATE = 2'd2,
        FUNC_CELL  = 2'd3
    } func_t;

    // register addresses
    localparam logic [0:0] REG_START_STATE = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_END_RD,
        ST_END_CHK,
        ST_POP,
        ST_RD_CUR,
        ST_RD_CELL,
        ST_DECIDE,
        ST_RD_RB,
        ST_WALK_RD,
        ST_WALK_PUSH,
        ST_EMIT,
        ST_DONE
    } ctrl_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic latch_in;
        logic write_state;
        logic write_cell;
        logic rd_cur;        // read entry of current state
        logic rd_rb;         // read entry of rollback state
        logic rd_walk;       // read entry of walk pointer
        logic rd_cell;       // read cell at base + op
        logic stack_clear;
        logic push_in_op;    // push input opcode
        logic push_op;       // push current op
        logic push_walk;     // push walk opcode
        logic pop;           // pop op into op register
        logic set_next;      // current <= cell target
        logic set_start;     // current <= start
        logic calc_k;        // compute rollback count, load walk pointer
        logic dec_k;
        logic emit_cur;      // queue result: current state
        logic emit_rb;       // queue result: rollback state
        logic res_clear;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        func_t func;
        logic  op_valid;
        logic  edge_hit;
        logic  at_start;
        logic  cur_term;
        logic  stack_empty;
        logic  k_zero;
        logic  res_full;
        logic  out_busy;
    } dp_stat_t;

endpackage

/* hw/rtl/lmsr_ctrl.sv */
// controller state machine for the recognizer
module lmsr_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lmsr_pkg::dp_stat_t stat,
    output lmsr_pkg::dp_cmd_t  cmd,
    output logic               run_done
);

    lmsr_pkg::ctrl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lmsr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        run_done   = 1'b0;
        case (state_reg)
            lmsr_pkg::ST_IDLE: begin
                s_ready = !stat.out_busy;
                if (s_valid && !stat.out_busy) begin
                    cmd.latch_in  = 1'b1;
                    cmd.res_clear = 1'b1;
                    state_next    = lmsr_pkg::ST_WRITE;
                end
            end
            lmsr_pkg::ST_WRITE: begin
                case (stat.func)
                    lmsr_pkg::FUNC_STATE: begin
                        cmd.write_state = 1'b1;
                        state_next      = lmsr_pkg::ST_IDLE;
                    end
                    lmsr_pkg::FUNC_CELL: begin
                        cmd.write_cell = 1'b1;
                        state_next     = lmsr_pkg::ST_IDLE;
                    end
                    lmsr_pkg::FUNC_END: begin
                        cmd.rd_cur = 1'b1;
                        state_next = lmsr_pkg::ST_END_RD;
                    end
                    default: begin
                        if (stat.op_valid) begin
                            cmd.stack_clear = 1'b1;
                            cmd.push_in_op  = 1'b1;
                            state_next      = lmsr_pkg::ST_POP;
                        end else begin
                            state_next = lmsr_pkg::ST_IDLE;
                        end
                    end
                endcase
            end
            lmsr_pkg::ST_END_RD: begin
                state_next = lmsr_pkg::ST_END_CHK;
            end
            lmsr_pkg::ST_END_CHK: begin
                if (stat.cur_term) begin
                    cmd.emit_cur = 1'b1;
                end
                cmd.set_start = 1'b1;
                state_next    = lmsr_pkg::ST_EMIT;
            end
            lmsr_pkg::ST_POP: begin
                if (stat.stack_empty) begin
                    state_next = lmsr_pkg::ST_EMIT;
                end else begin
                    cmd.pop    = 1'b1;
                    state_next = lmsr_pkg::ST_RD_CUR;
                end
            end
            lmsr_pkg::ST_RD_CUR: begin
                cmd.rd_cur = 1'b1;
                state_next = lmsr_pkg::ST_RD_CELL;
            end
            lmsr_pkg::ST_RD_CELL: begin
                cmd.rd_cell = 1'b1;
                state_next  = lmsr_pkg::ST_DECIDE;
            end
            lmsr_pkg::ST_DECIDE: begin
                if (stat.edge_hit) begin
                    cmd.set_next = 1'b1;
                    state_next   = lmsr_pkg::ST_POP;
                end else if (stat.at_start) begin
                    state_next = lmsr_pkg::ST_POP;
                end else if (stat.res_full) begin
                    cmd.stack_clear = 1'b1;
                    cmd.set_start   = 1'b1;
                    state_next      = lmsr_pkg::ST_EMIT;
                end else if (stat.cur_term) begin
                    cmd.emit_cur  = 1'b1;
                    cmd.set_start = 1'b1;
                    state_next    = lmsr_pkg::ST_RD_CUR;
                end else begin
                    cmd.emit_rb = 1'b1;
                    cmd.rd_rb   = 1'b1;
                    cmd.push_op = 1'b1;
                    state_next  = lmsr_pkg::ST_RD_RB;
                end
            end
            lmsr_pkg::ST_RD_RB: begin
                cmd.calc_k = 1'b1;
                state_next = lmsr_pkg::ST_WALK_RD;
            end
            lmsr_pkg::ST_WALK_RD: begin
                if (stat.k_zero) begin
                    cmd.set_start = 1'b1;
                    state_next    = lmsr_pkg::ST_POP;
                end else begin
                    cmd.rd_walk = 1'b1;
                    state_next  = lmsr_pkg::ST_WALK_PUSH;
                end
            end
            lmsr_pkg::ST_WALK_PUSH: begin
                cmd.push_walk = 1'b1;
                cmd.dec_k     = 1'b1;
                state_next    = lmsr_pkg::ST_WALK_RD;
            end
            lmsr_pkg::ST_EMIT: begin
                run_done   = 1'b1;
                state_next = lmsr_pkg::ST_DONE;
            end
            lmsr_pkg::ST_DONE: begin
                state_next = lmsr_pkg::ST_IDLE;
            end
            default: begin
                state_next = lmsr_pkg::ST_IDLE;
            end
        endcase
    end

    // a computed rollback count is always followed by the walk
    a_walk_after_rb: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lmsr_pkg::ST_RD_RB) |=> (state_reg == lmsr_pkg::ST_WALK_RD))
        else $error("rollback read not followed by walk");
    // no request taken while results drain
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.out_busy |-> !s_ready)
        else $error("request accepted while results pending");
    // a push and a pop never coincide
    a_push_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.pop && (cmd.push_op || cmd.push_walk || cmd.push_in_op)))
        else $error("push and pop in one cycle");

endmodule

/* hw/rtl/lmsr_datapath.sv */
// datapath: tables, replay stack, result queue
module lmsr_datapath #(
    parameter int STATE_COUNT  = lmsr_pkg::STATE_COUNT,
    parameter int CELL_COUNT   = lmsr_pkg::CELL_COUNT,
    parameter int OPCODE_COUNT = lmsr_pkg::OPCODE_COUNT,
    parameter int MAX_SEQ_LEN  = lmsr_pkg::MAX_SEQ_LEN
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lmsr_pkg::dp_cmd_t cmd,
    output lmsr_pkg::dp_stat_t stat,
    input  logic              run_done,
    input  logic [9:0]        start_state,
    input  logic [1:0]        s_func,
    input  logic [6:0]        s_opcode,
    input  logic [11:0]       s_entry_index,
    input  logic              s_is_terminal,
    input  logic [9:0]        s_longest_terminal,
    input  logic [3:0]        s_seq_length,
    input  logic [6:0]        s_last_opcode,
    input  logic [9:0]        s_prev_state,
    input  logic [11:0]       s_jump_base,
    input  logic [9:0]        s_cell_source,
    input  logic [9:0]        s_cell_target,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [9:0]        m_matched_state,
    output logic              m_last_of_run
);

    localparam int SA_W  = (STATE_COUNT > 2) ? $clog2(STATE_COUNT) : 1;
    localparam int CA_W  = (CELL_COUNT > 2) ? $clog2(CELL_COUNT) : 1;
    localparam int SP_W  = lmsr_pkg::SP_W;
    localparam int RES_W = lmsr_pkg::RES_W;
    localparam int SDEP  = lmsr_pkg::STACK_DEPTH;
    localparam int NRES  = lmsr_pkg::MAX_RESULTS;
    localparam int QA_W  = $clog2(NRES);

    // state entry: term, longest, len, opc, prev, base
    typedef struct packed {
        logic        term;
        logic [9:0]  longest;
        logic [3:0]  len;
        logic [6:0]  opc;
        logic [9:0]  prev;
        logic [11:0] base;
    } entry_t;

    entry_t      state_mem [STATE_COUNT];
    logic [19:0] cell_mem  [CELL_COUNT];
    logic [6:0]  stack_mem [SDEP];
    logic [9:0]  resq_mem  [NRES];

    // latched request
    logic [1:0]  func_reg;
    logic [6:0]  opin_reg;
    logic [11:0] idx_reg;
    entry_t      wentry_reg;
    logic [19:0] wcell_reg;

    logic [9:0]  cur_reg;
    logic [6:0]  op_reg;
    entry_t      rd_reg;       // registered state read
    logic        rd_ok_reg;    // read id was in range
    logic [19:0] cell_reg;
    logic        cell_ok_reg;
    logic [SP_W-1:0] sp_reg;
    logic [3:0]  curlen_reg;
    logic [9:0]  walk_reg;
    logic [3:0]  k_reg;
    logic [RES_W-1:0] nres_reg;
    logic [QA_W-1:0]  rdptr_reg;
    logic        busy_reg;

    // latch request
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            func_reg   <= s_func;
            opin_reg   <= s_opcode;
            idx_reg    <= s_entry_index;
            wentry_reg <= '{s_is_terminal, s_longest_terminal, s_seq_length,
                            s_last_opcode, s_prev_state, s_jump_base};
            wcell_reg  <= {s_cell_source, s_cell_target};
        end
    end

    // state table read address
    logic [9:0] rd_id;
    always_comb begin
        if (cmd.rd_rb) begin
            rd_id = rd_reg.longest;
        end else if (cmd.rd_walk) begin
            rd_id = walk_reg;
        end else begin
            rd_id = cur_reg;
        end
    end
    logic rd_in_range;
    assign rd_in_range = ({22'd0, rd_id} < 32'(STATE_COUNT));

    // state table
    always_ff @(posedge aclk) begin
        if (cmd.write_state && ({20'd0, idx_reg} < 32'(STATE_COUNT))) begin
            state_mem[idx_reg[SA_W-1:0]] <= wentry_reg;
        end
        if (cmd.rd_cur || cmd.rd_rb || cmd.rd_walk) begin
            rd_reg    <= state_mem[rd_id[SA_W-1:0]];
            rd_ok_reg <= rd_in_range;
        end
    end
    entry_t rd_e;
    assign rd_e = rd_ok_reg ? rd_reg : '0;

    // cell table, address base + op
    logic [12:0] caddr;
    assign caddr = {1'b0, rd_e.base} + {6'd0, op_reg};
    always_ff @(posedge aclk) begin
        if (cmd.write_cell && ({20'd0, idx_reg} < 32'(CELL_COUNT))) begin
            cell_mem[idx_reg[CA_W-1:0]] <= wcell_reg;
        end
        if (cmd.rd_cell) begin
            cell_reg    <= cell_mem[caddr[CA_W-1:0]];
            cell_ok_reg <= ({19'd0, caddr} < 32'(CELL_COUNT));
            curlen_reg  <= rd_e.len;
        end
    end

    // replay stack
    always_ff @(posedge aclk) begin
        if (cmd.push_in_op) begin
            stack_mem[0] <= opin_reg;
        end else if ((cmd.push_op || cmd.push_walk) && (32'(sp_reg) < SDEP)) begin
            stack_mem[sp_reg[SP_W-1:0]] <= cmd.push_op ? op_reg : rd_e.opc;
        end
        if (cmd.pop) begin
            op_reg <= stack_mem[sp_reg - SP_W'(1)];
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg <= '0;
        end else if (cmd.push_in_op) begin
            sp_reg <= SP_W'(1);
        end else if (cmd.stack_clear) begin
            sp_reg <= '0;
        end else if (cmd.pop) begin
            sp_reg <= sp_reg - SP_W'(1);
        end else if ((cmd.push_op || cmd.push_walk) && (32'(sp_reg) < SDEP)) begin
            sp_reg <= sp_reg + SP_W'(1);
        end
    end

    // rollback count and walk pointer
    logic [3:0] kraw;
    assign kraw = (curlen_reg > rd_e.len) ? (curlen_reg - rd_e.len) : 4'd0;
    always_ff @(posedge aclk) begin
        if (cmd.calc_k) begin
            k_reg    <= (32'(kraw) > MAX_SEQ_LEN - 1) ? 4'(MAX_SEQ_LEN - 1) : kraw;
            walk_reg <= cur_reg;
        end else if (cmd.dec_k) begin
            k_reg    <= k_reg - 4'd1;
            walk_reg <= rd_e.prev;
        end
    end

    // current state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= 10'd1;
        end else if (cmd.set_next) begin
            cur_reg <= cell_reg[9:0];
        end else if (cmd.set_start) begin
            cur_reg <= start_state;
        end
    end

    // result queue
    always_ff @(posedge aclk) begin
        if (cmd.emit_cur || cmd.emit_rb) begin
            resq_mem[nres_reg[QA_W-1:0]] <= cmd.emit_cur ? cur_reg : rd_e.longest;
        end
    end
    logic out_fire;
    assign out_fire = m_valid && m_ready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nres_reg  <= '0;
            rdptr_reg <= '0;
            busy_reg  <= 1'b0;
        end else begin
            if (cmd.res_clear) begin
                nres_reg <= '0;
            end else if (cmd.emit_cur || cmd.emit_rb) begin
                nres_reg <= nres_reg + RES_W'(1);
            end
            if (run_done) begin
                rdptr_reg <= '0;
                busy_reg  <= (nres_reg != '0);
            end else if (out_fire) begin
                if ({1'b0, rdptr_reg} == RES_W'(nres_reg - RES_W'(1))) begin
                    busy_reg <= 1'b0;
                end
                rdptr_reg <= rdptr_reg + QA_W'(1);
            end
        end
    end
    assign m_valid         = busy_reg;
    assign m_matched_state = resq_mem[rdptr_reg];
    assign m_last_of_run   = ({1'b0, rdptr_reg} == RES_W'(nres_reg - RES_W'(1)));

    // status
    logic [9:0] csrc;
    assign csrc = cell_reg[19:10];
    always_comb begin
        stat.func        = lmsr_pkg::func_t'(func_reg);
        stat.op_valid    = (32'(opin_reg) < OPCODE_COUNT);
        stat.edge_hit    = cell_ok_reg && (cur_reg != 10'd0) && (csrc == cur_reg)
                           && (cell_reg[9:0] != 10'd0);
        stat.at_start    = (cur_reg == start_state);
        stat.cur_term    = rd_e.term;
        stat.stack_empty = (sp_reg == '0);
        stat.k_zero      = (k_reg == 4'd0);
        stat.res_full    = (32'(nres_reg) >= NRES);
        stat.out_busy    = busy_reg;
    end

    // queue never exceeds its depth
    a_res_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(nres_reg) <= NRES)
        else $error("result count overflow");
    // no emit once the queue is full
    a_no_emit_full: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.res_full |-> !(cmd.emit_cur || cmd.emit_rb))
        else $error("emit beyond result limit");
    // stack pointer stays in range
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(sp_reg) <= SDEP)
        else $error("replay stack overflow");

endmodule

/* hw/rtl/longest_match_sequence_recognizer.sv */
// Longest-match sequence recognizer, top level.
// Input channel s_*: one request per handshake; func selects opcode feed,
// end of sequence, state entry write or transition cell write.
// Result channel m_*: matched terminal states, m_last_of_run marks the last
// result of a request. Up to eight results per request.
// A load request is latched and then written; an end request reads the
// current state, checks it and finishes. An opcode runs an overhead of latch,
// final stack check and finish, plus a pop, state read, cell read and decide
// for each opcode popped from the replay stack. A terminal emit retries the
// opcode; a rollback walks k opcodes, and each of the k + 1 replayed opcodes
// is popped, read and decided again. One request is worked on at a time.
// Results are queued and drained after the request; while the receiver
// stalls, the queue holds and no new request is taken.
// Reset: current state goes to start state 1, start_state register to 1,
// replay stack and result queue empty; tables are undefined until written.
// APB: start_state at address 0, pready always high.
module longest_match_sequence_recognizer #(
    parameter int STATE_COUNT  = lmsr_pkg::STATE_COUNT,
    parameter int CELL_COUNT   = lmsr_pkg::CELL_COUNT,
    parameter int OPCODE_COUNT = lmsr_pkg::OPCODE_COUNT,
    parameter int MAX_SEQ_LEN  = lmsr_pkg::MAX_SEQ_LEN
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [6:0]  s_opcode,
    input  logic [11:0] s_entry_index,
    input  logic        s_is_terminal,
    input  logic [9:0]  s_longest_terminal,
    input  logic [3:0]  s_seq_length,
    input  logic [6:0]  s_last_opcode,
    input  logic [9:0]  s_prev_state,
    input  logic [11:0] s_jump_base,
    input  logic [9:0]  s_cell_source,
    input  logic [9:0]  s_cell_target,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [9:0]  m_matched_state,
    output logic        m_last_of_run
);

    logic [9:0] start_state_reg;
    lmsr_pkg::dp_cmd_t  cmd;
    lmsr_pkg::dp_stat_t stat;
    logic run_done;

    // register file
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_state_reg <= 10'd1;
        end else if (psel && penable && pwrite && (paddr[1:0] == 2'd0)
                     && (paddr[2] == lmsr_pkg::REG_START_STATE)) begin
            start_state_reg <= pwdata[9:0];
        end
    end
    assign prdata = (paddr[2] == lmsr_pkg::REG_START_STATE)
                    ? {22'd0, start_state_reg} : 32'd0;

    lmsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .stat     (stat),
        .cmd      (cmd),
        .run_done (run_done)
    );

    lmsr_datapath #(
        .STATE_COUNT  (STATE_COUNT),
        .CELL_COUNT   (CELL_COUNT),
        .OPCODE_COUNT (OPCODE_COUNT),
        .MAX_SEQ_LEN  (MAX_SEQ_LEN)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .stat               (stat),
        .run_done           (run_done),
        .start_state        (start_state_reg),
        .s_func             (s_func),
        .s_opcode           (s_opcode),
        .s_entry_index      (s_entry_index),
        .s_is_terminal      (s_is_terminal),
        .s_longest_terminal (s_longest_terminal),
        .s_seq_length       (s_seq_length),
        .s_last_opcode      (s_last_opcode),
        .s_prev_state       (s_prev_state),
        .s_jump_base        (s_jump_base),
        .s_cell_source      (s_cell_source),
        .s_cell_target      (s_cell_target),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_matched_state    (m_matched_state),
        .m_last_of_run      (m_last_of_run)
    );

endmodule
